>>> hw/rtl/mhpq_pkg.sv
// Shared types, codes and defaults for the min-heap priority queue.
package mhpq_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int KEY_WIDTH        = 32;
   localparam int COUNT_OUT_WIDTH  = 11;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   typedef struct packed {
      logic    op;
      key_type key;
   } req_type;

   typedef struct packed {
      key_type                     min_key;
      status_type                  status;
      logic [COUNT_OUT_WIDTH-1:0]  entry_count;
   } rsp_type;

endpackage

>>> hw/rtl/min_heap_priority_queue_core.sv
// Binary min-heap priority queue of signed keys held in one memory.
//
// A transaction is taken on a rising edge with start high and busy low.
// req_item.op selects insert (key goes in) or extract (smallest key comes
// out). Every transaction gives exactly one result: rsp_valid is high for
// one cycle with rsp_item holding the extracted key (0 unless a good
// extract), a status (ok, full, empty) and the entry count afterwards.
// busy stays high while a sift is in progress; the next transaction may be
// started in the cycle the result is shown.
// A rejected insert or an extract on an empty heap answers in the cycle
// after the accepting edge. An insert climbs level by level from the end
// of the heap and answers once its key reaches the root or meets a parent
// that is not larger. An extract first fetches the root and the last entry,
// then moves that entry down level by level until it reaches a leaf or no
// child is smaller. Each level takes a memory read, then a compare-and-write
// step; for 1024 entries the longest transaction is an insert that climbs
// all ten levels to the root. The sifts move a hole rather than swapping, so
// every level needs only one write. Reset empties the heap at once; the
// memory is not cleared. The receiver cannot stall, so no result is ever held.
module min_heap_priority_queue_core #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhpq_pkg::req_type req_item,
   output logic              rsp_valid,
   output mhpq_pkg::rsp_type rsp_item
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = CW + 1;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_UP_RD    = 3'd1;
   localparam logic [2:0] ST_UP_CMP   = 3'd2;
   localparam logic [2:0] ST_DN_FETCH = 3'd3;
   localparam logic [2:0] ST_DN_RD    = 3'd4;
   localparam logic [2:0] ST_DN_CMP   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   key_type       key_ff, key_in;
   key_type       min_ff, min_in;
   logic          right_ok_ff, right_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   key_type       wr_data;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   key_type       rd_data_a;
   key_type       rd_data_b;

   logic          accept;
   logic          full;
   logic [AW-1:0] parent;
   logic [LW-1:0] left_idx;
   logic [LW-1:0] right_idx;
   logic [LW-1:0] count_ext;
   logic          pick_right;
   key_type       pick_val;
   logic [AW-1:0] pick_idx;
   logic [31:0]   count_wide;

   mhpq_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign full       = (count_ff == CW'(CAPACITY));
   assign parent     = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = LW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + LW'(1);
   assign count_ext  = LW'(count_ff);
   assign count_wide = 32'(count_ff);

   // Children are read together; the right one wins only when strictly smaller.
   assign pick_right = right_ok_ff && (rd_data_a > rd_data_b);
   assign pick_val   = pick_right ? rd_data_b : rd_data_a;
   assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      min_in       = min_ff;
      right_ok_in  = right_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = key_ff;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.op == OP_INSERT) begin
                  if (full) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.min_key     = '0;
                     rsp_in.status      = STATUS_FULL;
                     rsp_in.entry_count = count_wide[COUNT_OUT_WIDTH-1:0];
                  end else begin
                     key_in   = req_item.key;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.min_key     = '0;
                     rsp_in.status      = STATUS_EMPTY;
                     rsp_in.entry_count = '0;
                  end else begin
                     rd_addr_a = '0;
                     rd_addr_b = AW'(count_ff - CW'(1));
                     count_in  = count_ff - CW'(1);
                     state_in  = ST_DN_FETCH;
                  end
               end
            end
         end

         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en              = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.min_key     = '0;
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_count = count_wide[COUNT_OUT_WIDTH-1:0];
               state_in           = ST_IDLE;
            end else begin
               rd_addr_a = parent;
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data_a > key_ff) begin
               // The parent moves down into the hole and the hole climbs.
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = ST_UP_RD;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_in.min_key     = '0;
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_count = count_wide[COUNT_OUT_WIDTH-1:0];
               state_in           = ST_IDLE;
            end
         end

         ST_DN_FETCH: begin
            min_in   = rd_data_a;
            key_in   = rd_data_b;
            pos_in   = '0;
            state_in = ST_DN_RD;
         end

         ST_DN_RD: begin
            if (left_idx >= count_ext) begin
               wr_en              = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.min_key     = min_ff;
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_count = count_wide[COUNT_OUT_WIDTH-1:0];
               state_in           = ST_IDLE;
            end else begin
               rd_addr_a   = left_idx[AW-1:0];
               rd_addr_b   = right_idx[AW-1:0];
               right_ok_in = (right_idx < count_ext);
               state_in    = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff > pick_val) begin
               // The smaller child moves up into the hole and the hole descends.
               wr_data  = pick_val;
               pos_in   = pick_idx;
               state_in = ST_DN_RD;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_in.min_key     = min_ff;
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_count = count_wide[COUNT_OUT_WIDTH-1:0];
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      min_ff      <= min_in;
      right_ok_ff <= right_ok_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a sift is still running");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.op == OP_INSERT && full) |=>
         (rsp_valid && rsp_item.status == STATUS_FULL && !busy))
      else $error("insert on a full heap was not rejected");

   a_empty_extract: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.op == OP_EXTRACT && count_ff == '0) |=>
         (rsp_valid && rsp_item.status == STATUS_EMPTY && rsp_item.min_key == '0))
      else $error("extract on an empty heap was not flagged");

endmodule

>>> hw/rtl/mhpq_store.sv
// Key storage: one write port and two registered read ports.
module mhpq_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  mhpq_pkg::key_type    wr_data,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   output mhpq_pkg::key_type    rd_data_a,
   output mhpq_pkg::key_type    rd_data_b
);
   import mhpq_pkg::*;

   key_type mem [DEPTH];
   key_type rd_a_ff;
   key_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
